### rtl/core/dwse_pkg.sv
// ----------------------------------------------------------------------------
// dwse_pkg: shared types and codes for the deque core
// Transaction field widths, command codes and status codes.
// ----------------------------------------------------------------------------
package dwse_pkg;

   localparam int unsigned WordBits   = 32;
   localparam int unsigned IndexBits  = 8;
   localparam int unsigned CountBits  = 5;
   localparam int unsigned StatusBits = 2;

   typedef logic [2:0]            cmd_type;
   typedef logic [StatusBits-1:0] status_type;
   typedef logic [WordBits-1:0]   word_type;
   typedef logic [IndexBits-1:0]  index_type;
   typedef logic [CountBits-1:0]  count_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_READ_AT    = 3'd4;
   localparam cmd_type CMD_REMOVE     = 3'd5;
   localparam cmd_type CMD_CONTAINS   = 3'd6;
   localparam cmd_type CMD_CLEAR      = 3'd7;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

### rtl/core/dwse_ram.sv
// ----------------------------------------------------------------------------
// dwse_ram: generic single-write, single-read RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module dwse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/deque_with_search_engine_core.sv
// ----------------------------------------------------------------------------
// deque_with_search_engine_core: bounded double-ended queue with key search
// Circular word store with push/pop at both ends, indexed read, membership
// test, remove-first-match with compaction, and clear.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_cmd, req_value, req_index
//   rsp       out        rsp_valid/rsp_stall  rsp_data_out, rsp_hit,
//                                             rsp_status, rsp_count
//
// One transaction at a time; req_stall is high from accept until the result
// is moved into the output register. Push, clear and full/empty cases go
// straight to the result; pops wait for one RAM read, read-at runs the 8-step
// remainder unit and then one RAM read. Contains and remove are bounded by the
// single RAM read port walking the store. Reset (synchronous) empties the
// store at once; no clearing pass. A stalled result holds in the output
// register while the next transaction is accepted and worked on.
// ----------------------------------------------------------------------------
module deque_with_search_engine_core #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dwse_pkg::cmd_type    req_cmd,
   input  dwse_pkg::word_type   req_value,
   input  dwse_pkg::index_type  req_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dwse_pkg::word_type   rsp_data_out,
   output logic                 rsp_hit,
   output dwse_pkg::status_type rsp_status,
   output dwse_pkg::count_type  rsp_count
);
   import dwse_pkg::*;

   localparam int unsigned AddrW   = $clog2(DEPTH);
   localparam int unsigned CntW    = $clog2(DEPTH + 1);
   localparam int unsigned StoreW  = (WORD_WIDTH < WordBits) ? WORD_WIDTH : WordBits;
   localparam int unsigned BitCntW = $clog2(IndexBits);

   localparam logic [CntW-1:0]    CntFull   = CntW'(DEPTH);
   localparam logic [AddrW-1:0]   AddrLast  = AddrW'(DEPTH - 1);
   localparam logic [AddrW:0]     DepthWide = (AddrW + 1)'(DEPTH);
   localparam logic [BitCntW-1:0] BitLast   = BitCntW'(IndexBits - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOD    = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_SHIFT  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   function automatic logic [AddrW-1:0] phys_slot(input logic [AddrW-1:0] base,
                                                  input logic [AddrW-1:0] ofs);
      logic [AddrW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= DepthWide) begin
         sum = sum - DepthWide;
      end
      return sum[AddrW-1:0];
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [AddrW-1:0]   head_ff, head_in;
   logic [CntW-1:0]    count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic [StoreW-1:0]  key_ff, key_in;
   index_type          idx_ff, idx_in;
   logic [CntW-1:0]    rem_ff, rem_in;
   logic [BitCntW-1:0] bit_ff, bit_in;
   logic [CntW-1:0]    k_ff, k_in;
   logic               pend_ff, pend_in;
   logic [AddrW-1:0]   wr_k_ff, wr_k_in;
   logic [StoreW-1:0]  res_data_ff, res_data_in;
   logic               res_hit_ff, res_hit_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_data_ff, rsp_data_in;
   logic               rsp_hit_ff, rsp_hit_in;
   status_type         rsp_status_ff, rsp_status_in;
   count_type          rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic               wr_front;
   logic [AddrW-1:0]   wr_addr;
   logic [AddrW-1:0]   wr_k;
   logic [StoreW-1:0]  wr_data;
   logic [CntW-1:0]    rd_k;
   logic [AddrW-1:0]   rd_addr;
   logic [StoreW-1:0]  rd_data;

   logic [AddrW-1:0]   head_inc;
   logic [AddrW-1:0]   head_dec;
   logic [CntW-1:0]    count_dec;
   logic [CntW-1:0]    k_dec;
   logic               full;
   logic               empty;
   logic [CntW:0]      rem_trial;
   logic [CntW:0]      rem_next;

   assign head_inc  = (head_ff == AddrLast) ? '0 : head_ff + 1'b1;
   assign head_dec  = (head_ff == '0) ? AddrLast : head_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign k_dec     = k_ff - 1'b1;
   assign full      = (count_ff == CntFull);
   assign empty     = (count_ff == '0);

   // Restoring remainder step for read-at: one index bit per cycle
   assign rem_trial = {rem_ff, idx_ff[IndexBits-1]};
   assign rem_next  = (rem_trial >= {1'b0, count_ff}) ? rem_trial - {1'b0, count_ff}
                                                      : rem_trial;

   assign rd_addr = phys_slot(head_ff, rd_k[AddrW-1:0]);
   assign wr_addr = wr_front ? head_dec : phys_slot(head_ff, wr_k);

   dwse_ram #(
      .WIDTH (StoreW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      wr_k_in       = wr_k_ff;
      res_data_in   = res_data_ff;
      res_hit_in    = res_hit_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_front      = 1'b0;
      wr_k          = '0;
      wr_data       = rd_data;
      rd_k          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               key_in        = req_value[StoreW-1:0];
               idx_in        = req_index;
               rem_in        = '0;
               bit_in        = '0;
               k_in          = '0;
               pend_in       = 1'b0;
               res_data_in   = '0;
               res_hit_in    = 1'b0;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
               wr_data       = req_value[StoreW-1:0];
               unique case (req_cmd)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_front = 1'b1;
                        head_in  = head_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_k     = count_ff[AddrW-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_dec;
                        state_in = S_RDWAIT;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_k     = count_dec;
                        count_in = count_dec;
                        state_in = S_RDWAIT;
                     end
                  end
                  CMD_READ_AT: begin
                     if (empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  CMD_REMOVE, CMD_CONTAINS: begin
                     state_in = S_SCAN;
                  end
                  CMD_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MOD: begin
            rem_in = rem_next[CntW-1:0];
            idx_in = idx_ff << 1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BitLast) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            rd_k     = rem_ff;
            state_in = S_RDWAIT;
         end
         S_RDWAIT: begin
            res_data_in = rd_data;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            // Read of entry k_ff issued here; data for k_ff-1 checked here
            rd_k = k_ff;
            if (pend_ff && (rd_data == key_ff)) begin
               res_hit_in = 1'b1;
               pend_in    = 1'b0;
               state_in   = (cmd_ff == CMD_REMOVE) ? S_SHIFT : S_DONE;
            end else if (k_ff < count_ff) begin
               pend_in = 1'b1;
               k_in    = k_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // Move entry j+1 into j, one per cycle, read and write overlapped
            rd_k    = k_ff;
            wr_k    = wr_k_ff;
            wr_en   = pend_ff;
            wr_data = rd_data;
            if (k_ff < count_ff) begin
               pend_in = 1'b1;
               wr_k_in = k_dec[AddrW-1:0];
               k_in    = k_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_dec;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = WordBits'(res_data_ff);
               rsp_hit_in    = res_hit_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = CountBits'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      k_ff          <= k_in;
      wr_k_ff       <= wr_k_in;
      res_data_ff   <= res_data_in;
      res_hit_ff    <= res_hit_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("entry count beyond depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_IDLE || state_ff == S_SHIFT))
      else $error("store written outside push or compaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction left no work");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |=> (count_ff == $past(count_ff) || state_ff == S_DONE))
      else $error("count changed during compaction");

endmodule
